// ----- rtl/core/calibration_table_interpolator_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Calibration table interpolator - assertion macros
// Immediate-implication and next-cycle-implication checks on clk / arst_n.
// ----------------------------------------------------------------------------
`ifndef CALIBRATION_TABLE_INTERPOLATOR_UNIT_DEFINES_SVH
`define CALIBRATION_TABLE_INTERPOLATOR_UNIT_DEFINES_SVH

// pre holds -> post holds in the same cycle
`define CTI_AST_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// pre holds -> post holds in the next cycle
`define CTI_AST_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- rtl/core/cti_pkg.sv -----
// ----------------------------------------------------------------------------
// cti_pkg
// Types and constants of the calibration table interpolator.
// ----------------------------------------------------------------------------
package cti_pkg;

	localparam int CHANNELS  = 4;
	localparam int POINTS    = 16;
	localparam int CH_W      = $clog2(CHANNELS);
	localparam int PT_W      = $clog2(POINTS);
	localparam int ENTRIES   = CHANNELS * POINTS;
	localparam int ADDR_W    = CH_W + PT_W;

	localparam int ADC_W     = 12;
	localparam int MA_W      = 16;
	localparam int PTS_W     = 5;
	localparam logic [PTS_W-1:0] PTS_RESET = PTS_W'(13);
	localparam logic [PTS_W-1:0] PTS_MIN   = PTS_W'(2);
	localparam logic [PTS_W-1:0] PTS_MAX   = PTS_W'(POINTS);

	localparam int NUM_W     = ADC_W + MA_W;
	localparam int DIV_STEPS = NUM_W / 2;
	localparam int CNT_W     = $clog2(DIV_STEPS + 1);

	typedef enum logic {
		MODE_LOAD    = 1'b0,
		MODE_CONVERT = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t              mode;
		logic [1:0]         channel;
		logic [3:0]         point_index;
		logic [ADC_W-1:0]   point_adc;
		logic [MA_W-1:0]    point_ma;
		logic [ADC_W-1:0]   raw_sample;
	} cti_req_t;

	typedef struct packed {
		logic [1:0]         result_channel;
		logic [MA_W-1:0]    current_ma;
	} cti_res_t;

	typedef struct packed {
		logic [ADC_W-1:0]   adc;
		logic [MA_W-1:0]    ma;
	} cti_point_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIRST,
		ST_LAST,
		ST_SCAN,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} cti_state_t;

endpackage

// ----- rtl/core/calibration_table_interpolator_unit.sv -----
// ----------------------------------------------------------------------------
// calibration_table_interpolator_unit
// Per-channel piecewise-linear calibration lookup over a point table in RAM.
// ----------------------------------------------------------------------------
//  port group     direction  handshake           payload
//  request        in         start / busy        req  (cti_req_t)
//  result         out        done (1-cycle)      res  (cti_res_t)
//  config         in         cfg_we              cfg_wdata (points in use)
//
//  Load requests write the table in the accept cycle; busy never rises.
//  Convert: reads the first and last points and clamps to an end point;
//  else scans segments (1 to 15) with one table read per cycle, then runs
//  a 2-bit-per-cycle divider unless the segment is zero-width or no segment
//  holds the sample. No clearing pass after reset; done cannot stall.
// ----------------------------------------------------------------------------
`include "calibration_table_interpolator_unit_defines.svh"

module calibration_table_interpolator_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  cti_pkg::cti_req_t        req,
	input  logic                     cfg_we,
	input  logic [cti_pkg::PTS_W-1:0] cfg_wdata,
	output logic                     done,
	output cti_pkg::cti_res_t        res
);
	import cti_pkg::*;

	cti_state_t          state_q, state_d;
	logic [PTS_W-1:0]    pts_q;
	logic                done_q;
	cti_res_t            res_q;

	cti_point_t          cal_mem [ENTRIES];
	cti_point_t          rd_data_q;
	logic [ADDR_W-1:0]   rd_addr;

	cti_point_t          lo_q;
	logic [CH_W-1:0]     ch_q;
	logic [PT_W-1:0]     last_q;
	logic [PT_W-1:0]     idx_q;
	logic [ADC_W-1:0]    raw_q;
	logic [ADC_W-1:0]    pos_q;
	logic [ADC_W-1:0]    dx_q;
	logic [MA_W-1:0]     dy_q;
	logic                neg_q;
	logic [NUM_W-1:0]    num_q;
	logic [ADC_W:0]      rem_q;
	logic [CNT_W-1:0]    cnt_q;

	logic                accept, conv_acc, load_acc;
	logic [PTS_W-1:0]    n_pts;
	logic                below_first, above_last, seg_hit, seg_zero, scan_end, div_last;
	logic                emit;
	logic [MA_W-1:0]     emit_ma;
	logic [NUM_W-1:0]    div_num_d;
	logic [ADC_W:0]      div_rem_d;
	logic signed [NUM_W+1:0] sum;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign conv_acc = accept && (req.mode == MODE_CONVERT);
	assign load_acc = accept && (req.mode == MODE_LOAD);

	always_comb begin
		if (pts_q < PTS_MIN)
			n_pts = PTS_MIN;
		else if (pts_q > PTS_MAX)
			n_pts = PTS_MAX;
		else
			n_pts = pts_q;
	end

	assign below_first = (raw_q <= lo_q.adc);
	assign above_last  = (raw_q >= rd_data_q.adc);
	assign seg_hit     = (raw_q >= lo_q.adc) && (raw_q <= rd_data_q.adc);
	assign seg_zero    = (rd_data_q.adc == lo_q.adc);
	assign scan_end    = (idx_q == last_q);
	assign div_last    = (cnt_q == CNT_W'(1));

	// restoring divider, two quotient bits per cycle
	always_comb begin
		logic [ADC_W:0] trial;
		div_num_d = num_q;
		div_rem_d = rem_q;
		for (int k = 0; k < 2; k++) begin
			trial     = {div_rem_d[ADC_W-1:0], div_num_d[NUM_W-1]};
			div_num_d = {div_num_d[NUM_W-2:0], 1'b0};
			if (trial >= {1'b0, dx_q}) begin
				div_rem_d    = trial - {1'b0, dx_q};
				div_num_d[0] = 1'b1;
			end else begin
				div_rem_d = trial;
			end
		end
	end

	always_comb begin
		if (neg_q)
			sum = $signed({{(NUM_W+2-MA_W){1'b0}}, lo_q.ma}) - $signed({2'b00, num_q});
		else
			sum = $signed({{(NUM_W+2-MA_W){1'b0}}, lo_q.ma}) + $signed({2'b00, num_q});
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (conv_acc) state_d = ST_FIRST;
			ST_FIRST: state_d = ST_LAST;
			ST_LAST: begin
				if (below_first || above_last)
					state_d = ST_IDLE;
				else
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (seg_hit)
					state_d = seg_zero ? ST_IDLE : ST_MUL;
				else if (scan_end)
					state_d = ST_IDLE;
			end
			ST_MUL:   state_d = ST_DIV;
			ST_DIV:   if (div_last) state_d = ST_FIN;
			ST_FIN:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs: table read address and result emission
	always_comb begin
		rd_addr = {ch_q, idx_q};
		emit    = 1'b0;
		emit_ma = '0;
		unique case (state_q)
			ST_IDLE:  rd_addr = {req.channel[CH_W-1:0], PT_W'(0)};
			ST_FIRST: rd_addr = {ch_q, last_q};
			ST_LAST: begin
				rd_addr = {ch_q, PT_W'(1)};
				if (below_first) begin
					emit    = 1'b1;
					emit_ma = lo_q.ma;
				end else if (above_last) begin
					emit    = 1'b1;
					emit_ma = rd_data_q.ma;
				end
			end
			ST_SCAN: begin
				rd_addr = {ch_q, idx_q + PT_W'(1)};
				if (seg_hit) begin
					emit    = seg_zero;
					emit_ma = lo_q.ma;
				end else if (scan_end) begin
					emit    = 1'b1;
					emit_ma = '0;
				end
			end
			ST_FIN: begin
				emit = 1'b1;
				if (sum < 0)
					emit_ma = '0;
				else if (sum > $signed((NUM_W+2)'({MA_W{1'b1}})))
					emit_ma = '1;
				else
					emit_ma = sum[MA_W-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pts_q   <= PTS_RESET;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
			if (cfg_we)
				pts_q <= cfg_wdata;
		end
	end

	// table RAM; only one request in flight, so a load never meets a read it affects
	always_ff @(posedge clk) begin
		if (load_acc)
			cal_mem[{req.channel[CH_W-1:0], req.point_index[PT_W-1:0]}] <=
				'{adc: req.point_adc, ma: req.point_ma};
		rd_data_q <= cal_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (emit)
			res_q <= '{result_channel: 2'(ch_q), current_ma: emit_ma};
		unique case (state_q)
			ST_IDLE: begin
				if (conv_acc) begin
					ch_q   <= req.channel[CH_W-1:0];
					raw_q  <= req.raw_sample;
					last_q <= PT_W'(n_pts - PTS_W'(1));
				end
			end
			ST_FIRST: lo_q <= rd_data_q;
			ST_LAST:  idx_q <= PT_W'(1);
			ST_SCAN: begin
				if (seg_hit) begin
					pos_q <= raw_q - lo_q.adc;
					dx_q  <= rd_data_q.adc - lo_q.adc;
					neg_q <= (rd_data_q.ma < lo_q.ma);
					dy_q  <= (rd_data_q.ma < lo_q.ma) ? (lo_q.ma - rd_data_q.ma)
					                                  : (rd_data_q.ma - lo_q.ma);
				end else begin
					lo_q  <= rd_data_q;
					idx_q <= idx_q + PT_W'(1);
				end
			end
			ST_MUL: begin
				num_q <= NUM_W'(pos_q) * NUM_W'(dy_q);
				rem_q <= '0;
				cnt_q <= CNT_W'(DIV_STEPS);
			end
			ST_DIV: begin
				num_q <= div_num_d;
				rem_q <= div_rem_d;
				cnt_q <= cnt_q - CNT_W'(1);
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign res  = res_q;

	`CTI_AST_NOW(a_done_idle, done, !busy, "result strobe while busy")
	`CTI_AST_NEXT(a_conv_busy, start && !busy && req.mode == MODE_CONVERT, busy, "convert not taken")
	`CTI_AST_NEXT(a_load_quiet, start && !busy && req.mode == MODE_LOAD, !done, "load gave a result")
	`CTI_AST_NOW(a_div_count, state_q == ST_DIV, cnt_q != '0, "divider count ran out")

endmodule
